// ===== rtl/core/srids_pkg.sv =====
// ----------------------------------------------------------------------------
// srids_pkg: shared types and helpers for sparse row inverse diagonal scaling
// Item and result payloads, queue entry types, state codes and the clamp to
// the signed 32-bit fixed-point range.
// ----------------------------------------------------------------------------
`default_nettype none

package srids_pkg;

  localparam int INDEX_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int IDX_W          = 16;
  localparam int VAL_W          = 32;

  localparam logic [VAL_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [63:0]      POS_LIM = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0]      NEG_LIM = 64'h0000_0000_8000_0000;

  typedef struct packed {
    logic                    command;
    logic                    first_in_row;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] scaled_value;
    logic                    saturated;
    logic                    no_diagonal;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_ENTRY,
    KIND_OPEN_DIAG,
    KIND_OPEN_OFF,
    KIND_RHS
  } item_kind_t;

  typedef struct packed {
    item_kind_t              kind;
    logic signed [VAL_W-1:0] value;
  } queue_item_t;

  typedef struct packed {
    logic        valid;
    queue_item_t item;
  } queue_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_MUL,
    BK_RND
  } back_state_t;

  typedef struct packed {
    logic [VAL_W-1:0] bits;
    logic             sat;
  } clamp_t;

  function automatic logic [VAL_W-1:0] mag32(input logic signed [VAL_W-1:0] v);
    logic [VAL_W-1:0] m;
    m = v[VAL_W-1] ? (32'd0 - v) : v;
    return m;
  endfunction

  // Clamp a sign and magnitude to 32-bit two's complement.
  function automatic clamp_t clamp_mag(input logic neg, input logic [63:0] m);
    clamp_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (m > NEG_LIM) begin
        r.sat  = 1'b1;
        r.bits = NEG_LIM[VAL_W-1:0];
      end else begin
        r.bits = 32'd0 - m[VAL_W-1:0];
      end
    end else begin
      if (m > POS_LIM) begin
        r.sat  = 1'b1;
        r.bits = POS_MAX;
      end else begin
        r.bits = m[VAL_W-1:0];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/srids_front.sv =====
// ----------------------------------------------------------------------------
// srids_front: request classifier and two-entry queue
// Sorts each incoming request into row opening (diagonal or not), plain entry
// or right-hand side, and holds it until the back end takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module srids_front #(
  parameter int INDEX_BITS = srids_pkg::INDEX_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  srids_pkg::in_item_t    in_data,
  output srids_pkg::queue_stat_t q_stat,
  input  wire                    q_pop
);

  localparam int CMP_W = (INDEX_BITS < srids_pkg::IDX_W) ? INDEX_BITS : srids_pkg::IDX_W;

  srids_pkg::queue_item_t mem_r [2];
  logic                   wr_ptr_r, wr_ptr_nxt;
  logic                   rd_ptr_r, rd_ptr_nxt;
  logic [1:0]             count_r, count_nxt;
  logic                   push;
  srids_pkg::queue_item_t new_item;

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid & ~in_stall;

  always_comb begin
    new_item.value = in_data.value;
    if (in_data.command) begin
      new_item.kind = srids_pkg::KIND_RHS;
    end else if (in_data.first_in_row) begin
      if (in_data.col_index[CMP_W-1:0] == in_data.row_index[CMP_W-1:0]) begin
        new_item.kind = srids_pkg::KIND_OPEN_DIAG;
      end else begin
        new_item.kind = srids_pkg::KIND_OPEN_OFF;
      end
    end else begin
      new_item.kind = srids_pkg::KIND_ENTRY;
    end
  end

  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

  assign q_stat.valid = (count_r != 2'd0);
  assign q_stat.item  = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

// ===== rtl/core/srids_recip.sv =====
// ----------------------------------------------------------------------------
// srids_recip: fixed-point reciprocal
// Restoring divider, one quotient bit per cycle, giving the rounded and
// clamped value of 2^(2*FRAC_BITS) / value for a nonzero value.
// ----------------------------------------------------------------------------
`default_nettype none

module srids_recip #(
  parameter int FRAC_BITS = srids_pkg::FRAC_BITS_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  input  wire signed [31:0]     value,
  output logic                  done,
  output srids_pkg::clamp_t     result
);

  localparam int NUM_W = ((2 * FRAC_BITS > 31) ? 2 * FRAC_BITS : 31) + 1;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             neg_r, neg_nxt;
  logic [31:0]      div_r, div_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [32:0]      rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [32:0]      rem_sh;
  logic [33:0]      diff;
  logic             ge;

  assign rem_sh = {rem_r[31:0], num_r[NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, div_r};
  assign ge     = ~diff[33];

  always_comb begin
    logic [31:0] mag;
    mag      = srids_pkg::mag32(value);
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    div_nxt  = div_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      // Numerator carries half the divisor so the quotient comes out rounded.
      neg_nxt  = value[31];
      div_nxt  = mag;
      num_nxt  = (NUM_W'(1) << (2 * FRAC_BITS)) + NUM_W'(mag >> 1);
      rem_nxt  = 33'd0;
      quo_nxt  = '0;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = num_r << 1;
      rem_nxt = ge ? diff[32:0] : rem_sh;
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    div_r <= div_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done   = done_r;
  assign result = srids_pkg::clamp_mag(neg_r, 64'(quo_r));

endmodule

`default_nettype wire

// ===== rtl/core/srids_back.sv =====
// ----------------------------------------------------------------------------
// srids_back: row scale state and scaling datapath
// Keeps the open row's scale, starts the reciprocal on a nonzero diagonal row opening,
// multiplies each value by the scale, rounds, clamps and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module srids_back #(
  parameter int FRAC_BITS = srids_pkg::FRAC_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  srids_pkg::queue_stat_t q_stat,
  output logic                   q_pop,
  output logic                   div_start,
  output logic signed [31:0]     div_value,
  input  wire                    div_done,
  input  srids_pkg::clamp_t      div_result,
  output logic                   out_valid,
  input  wire                    out_stall,
  output srids_pkg::out_item_t   out_data
);

  srids_pkg::back_state_t state_r, state_nxt;
  srids_pkg::item_kind_t  kind_r, kind_nxt;
  logic signed [31:0]     val_r, val_nxt;
  logic [31:0]            scale_r, scale_nxt;
  logic                   has_r, has_nxt;
  logic                   rsat_r, rsat_nxt;
  logic [63:0]            prod_r, prod_nxt;
  logic                   pneg_r, pneg_nxt;
  logic                   out_valid_r, out_valid_nxt;
  srids_pkg::out_item_t   out_data_r, out_data_nxt;

  logic [31:0]            scale_eff;
  logic [63:0]            rnd;
  srids_pkg::clamp_t      res;
  logic                   out_free;

  assign scale_eff = has_r ? scale_r : 32'd0;
  assign rnd       = (prod_r + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign res       = srids_pkg::clamp_mag(pneg_r && (rnd != 64'd0), rnd);
  assign out_free  = ~out_valid_r | ~out_stall;
  assign div_value = q_stat.item.value;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    val_nxt       = val_r;
    scale_nxt     = scale_r;
    has_nxt       = has_r;
    rsat_nxt      = rsat_r;
    prod_nxt      = prod_r;
    pneg_nxt      = pneg_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & out_stall;
    q_pop         = 1'b0;
    div_start     = 1'b0;
    unique case (state_r)
      srids_pkg::BK_IDLE: begin
        if (q_stat.valid) begin
          q_pop     = 1'b1;
          kind_nxt  = q_stat.item.kind;
          val_nxt   = q_stat.item.value;
          rsat_nxt  = 1'b0;
          state_nxt = srids_pkg::BK_MUL;
          case (q_stat.item.kind)
            srids_pkg::KIND_OPEN_DIAG: begin
              has_nxt = 1'b1;
              if (q_stat.item.value == 32'sd0) begin
                // A zero diagonal acts like an infinite reciprocal.
                scale_nxt = srids_pkg::POS_MAX;
                rsat_nxt  = 1'b1;
              end else begin
                div_start = 1'b1;
                state_nxt = srids_pkg::BK_DIV;
              end
            end
            srids_pkg::KIND_OPEN_OFF: begin
              scale_nxt = 32'd0;
              has_nxt   = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      srids_pkg::BK_DIV: begin
        if (div_done) begin
          scale_nxt = div_result.bits;
          rsat_nxt  = div_result.sat;
          state_nxt = srids_pkg::BK_MUL;
        end
      end
      srids_pkg::BK_MUL: begin
        prod_nxt  = {32'd0, srids_pkg::mag32(val_r)} * {32'd0, srids_pkg::mag32(scale_eff)};
        pneg_nxt  = val_r[31] ^ scale_eff[31];
        state_nxt = srids_pkg::BK_RND;
      end
      srids_pkg::BK_RND: begin
        if (out_free) begin
          out_data_nxt.scaled_value = res.bits;
          out_data_nxt.saturated    = res.sat | rsat_r;
          out_data_nxt.no_diagonal  = ~has_r;
          out_valid_nxt             = 1'b1;
          if (kind_r == srids_pkg::KIND_RHS) begin
            scale_nxt = 32'd0;
            has_nxt   = 1'b0;
          end
          state_nxt = srids_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = srids_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srids_pkg::BK_IDLE;
      scale_r     <= 32'd0;
      has_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scale_r     <= scale_nxt;
      has_r       <= has_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    val_r      <= val_nxt;
    rsat_r     <= rsat_nxt;
    prod_r     <= prod_nxt;
    pneg_r     <= pneg_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/sparse_row_inverse_diag_scale.sv =====
// ----------------------------------------------------------------------------
// sparse_row_inverse_diag_scale: Jacobi row scaling of a sparse row stream
// Scales each row's entries and right-hand side by the reciprocal of the
// row's leading diagonal, in signed fixed point with saturation.
// ----------------------------------------------------------------------------
// Each request gives one result, in order. Requests enter a two-entry queue
// and the back end handles one at a time: a plain entry, an off-diagonal row
// opening or a right-hand-side value passes through three steps (pick up,
// multiply, round and clamp), and the next request is picked up only once
// the last one is rounded and clamped. A row that opens on a nonzero diagonal
// also runs the bit-serial reciprocal between pick-up and multiply, once per
// row. A full queue raises in_stall; a result waits in the output register
// under out_stall while the next request is being worked.
`default_nettype none

module sparse_row_inverse_diag_scale #(
  parameter int INDEX_BITS = srids_pkg::INDEX_BITS_DEF,
  parameter int FRAC_BITS  = srids_pkg::FRAC_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  srids_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output srids_pkg::out_item_t out_data
);

  srids_pkg::queue_stat_t q_stat;
  logic                   q_pop;
  logic                   div_start;
  logic signed [31:0]     div_value;
  logic                   div_done;
  srids_pkg::clamp_t      div_result;

  srids_front #(
    .INDEX_BITS(INDEX_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .q_stat  (q_stat),
    .q_pop   (q_pop)
  );

  srids_recip #(
    .FRAC_BITS(FRAC_BITS)
  ) u_recip (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .value (div_value),
    .done  (div_done),
    .result(div_result)
  );

  srids_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .div_start (div_start),
    .div_value (div_value),
    .div_done  (div_done),
    .div_result(div_result),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // The back end never takes a request from an empty queue.
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_stat.valid)
    else $error("queue popped while empty");

  // A full queue must hold a request for the back end.
  assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> q_stat.valid)
    else $error("input stalled with nothing queued");

  // The reciprocal only starts on a request just taken from the queue.
  assert property (@(posedge clk) disable iff (!rst_n) div_start |-> q_pop)
    else $error("reciprocal started without a request");

  // The reciprocal does not report done straight after a start.
  assert property (@(posedge clk) disable iff (!rst_n) div_start |=> !div_done)
    else $error("reciprocal finished too early");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for sparse_row_inverse_diag_scale
// Streams rows of sparse entries, each closed by a right-hand-side request,
// and checks every scaled result against an in-bench model of the reciprocal
// diagonal scaling with rounding and saturation. Covers corner values,
// backpressure that fills the block, a drain pause and long random runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int FRAC = 16;
  localparam int STUCK_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 50;
  localparam logic CMD_ENTRY = 1'b0;
  localparam logic CMD_RHS = 1'b1;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;
  localparam logic [31:0] Q_TOP = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_BOTTOM = 32'h8000_0000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  srids_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  srids_pkg::out_item_t out_data;

  srids_pkg::out_item_t expected_results[$];
  logic [31:0] open_scale = '0;
  logic row_open = 1'b0;
  int error_count = 0;
  int requests_sent = 0;
  int stuck_cycles = 0;
  int long_hold_cycles = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;

  sparse_row_inverse_diag_scale uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Returns {saturated, bits} for a sign and magnitude.
  function automatic logic [32:0] clamp_q(input logic neg, input logic [63:0] m);
    if (neg) begin
      if (m > {32'd0, Q_BOTTOM}) return {1'b1, Q_BOTTOM};
      return {1'b0, 32'd0 - m[31:0]};
    end
    if (m > {32'd0, Q_TOP}) return {1'b1, Q_TOP};
    return {1'b0, m[31:0]};
  endfunction

  function automatic logic [63:0] magnitude(input logic [31:0] v);
    return v[31] ? {32'd0, 32'd0 - v} : {32'd0, v};
  endfunction

  function automatic logic [32:0] reciprocal(input logic [31:0] v);
    logic [63:0] m;
    logic [63:0] q;
    if (v == 32'd0) return {1'b1, Q_TOP};
    m = magnitude(v);
    q = ((64'd1 << (2 * FRAC)) + (m >> 1)) / m;
    return clamp_q(v[31], q);
  endfunction

  function automatic logic [32:0] product(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = magnitude(a) * magnitude(b);
    p = (p + (64'd1 << (FRAC - 1))) >> FRAC;
    return clamp_q((a[31] ^ b[31]) && p != 64'd0, p);
  endfunction

  // Advances the row state by one request and returns the result it must give.
  function automatic srids_pkg::out_item_t scale_request(input srids_pkg::in_item_t it);
    srids_pkg::out_item_t res;
    logic [32:0] r;
    logic [32:0] p;
    logic sat;
    sat = 1'b0;
    if (it.command == CMD_ENTRY && it.first_in_row) begin
      if (it.col_index == it.row_index) begin
        r = reciprocal(it.value);
        open_scale = r[31:0];
        sat = r[32];
        row_open = 1'b1;
      end else begin
        open_scale = '0;
        row_open = 1'b0;
      end
    end
    p = product(it.value, row_open ? open_scale : 32'd0);
    res.scaled_value = p[31:0];
    res.saturated = sat | p[32];
    res.no_diagonal = ~row_open;
    if (it.command == CMD_RHS) begin
      open_scale = '0;
      row_open = 1'b0;
    end
    return res;
  endfunction

  function automatic srids_pkg::in_item_t make_item(input logic cmd, input logic first,
                                                     input logic [15:0] row,
                                                     input logic [15:0] col,
                                                     input logic [31:0] val);
    srids_pkg::in_item_t it;
    it.command = cmd;
    it.first_in_row = first;
    it.row_index = row;
    it.col_index = col;
    it.value = val;
    return it;
  endfunction

  function automatic logic [31:0] random_value();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = Q_ONE + $urandom_range(0, 255) - 128;
      1: begin
        case ($urandom_range(0, 4))
          0: v = Q_TOP;
          1: v = Q_BOTTOM;
          2: v = 32'd0;
          3: v = 32'd1;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      2, 3: begin
        v = $urandom_range(1 << 8, 1 << 22);
        if ($urandom_range(0, 1)) v = 32'd0 - v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < 40)
      $display("%0t mismatch in %s: got %h, want %h", $time, what, got, want);
    error_count++;
  endtask

  task automatic send_request(input srids_pkg::in_item_t it);
    int gap;
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(scale_request(it));
    requests_sent++;
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_row();
    logic [15:0] row;
    logic [15:0] col;
    int entries;
    row = $urandom;
    // Most rows open on their diagonal; the rest on some other column.
    col = ($urandom_range(0, 4) != 0) ? row : row ^ 16'($urandom_range(1, 65535));
    entries = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
    if (entries > 0) begin
      send_request(make_item(CMD_ENTRY, 1'b1, row, col,
                             ($urandom_range(0, 2) == 0) ? random_value()
                                                         : Q_ONE + $urandom_range(0, 1 << 17)));
      repeat (entries - 1)
        send_request(make_item(CMD_ENTRY, 1'b0, row, 16'($urandom), random_value()));
    end
    send_request(make_item(CMD_RHS, 1'($urandom), 16'($urandom), 16'($urandom),
                           random_value()));
  endtask

  task automatic test_directed_corners();
    // Right-hand side with no row open, then an entry with no row open.
    send_request(make_item(CMD_RHS, 1'b1, 16'd5, 16'd5, Q_ONE));
    send_request(make_item(CMD_ENTRY, 1'b0, 16'd5, 16'd5, Q_TOP));
    // Unit diagonal at the top index, extreme entries pass through unchanged.
    send_request(make_item(CMD_ENTRY, 1'b1, 16'hFFFF, 16'hFFFF, Q_ONE));
    send_request(make_item(CMD_ENTRY, 1'b0, 16'hFFFF, 16'h0000, Q_TOP));
    send_request(make_item(CMD_ENTRY, 1'b0, 16'hFFFF, 16'h8000, Q_BOTTOM));
    send_request(make_item(CMD_RHS, 1'b0, 16'h0000, 16'h0000, 32'hFFFF_FFFF));
    // Zero diagonal saturates the scale, then products saturate both ways.
    send_request(make_item(CMD_ENTRY, 1'b1, 16'd7, 16'd7, 32'd0));
    send_request(make_item(CMD_ENTRY, 1'b0, 16'd7, 16'd3, Q_ONE));
    send_request(make_item(CMD_ENTRY, 1'b0, 16'd7, 16'd9, 32'h0002_0000));
    send_request(make_item(CMD_RHS, 1'b0, 16'd7, 16'd7, 32'hFFFE_0000));
    // Smallest negative diagonal: the reciprocal clamps at the bottom.
    send_request(make_item(CMD_ENTRY, 1'b1, 16'd2, 16'd2, 32'hFFFF_FFFF));
    send_request(make_item(CMD_ENTRY, 1'b0, 16'd2, 16'd0, 32'd1));
    send_request(make_item(CMD_RHS, 1'b0, 16'd2, 16'd2, 32'd0));
    // Most negative diagonal gives the smallest nonzero scale.
    send_request(make_item(CMD_ENTRY, 1'b1, 16'h8000, 16'h8000, Q_BOTTOM));
    send_request(make_item(CMD_ENTRY, 1'b0, 16'h8000, 16'h0001, Q_TOP));
    send_request(make_item(CMD_RHS, 1'b1, 16'h4321, 16'h1234, 32'h0003_0000));
    // Row that opens off its diagonal.
    send_request(make_item(CMD_ENTRY, 1'b1, 16'h1234, 16'h4321, Q_ONE));
    send_request(make_item(CMD_ENTRY, 1'b0, 16'h1234, 16'h1234, 32'h0005_0000));
    send_request(make_item(CMD_RHS, 1'b0, 16'h1234, 16'h0000, 32'h0001_8000));
    // Diagonal of three raw units needs rounding of the reciprocal.
    send_request(make_item(CMD_ENTRY, 1'b1, 16'd100, 16'd100, 32'd3));
    send_request(make_item(CMD_RHS, 1'b0, 16'd100, 16'd100, 32'd1));
    // Half diagonal: products land exactly on the negative limit and just past
    // the positive one.
    send_request(make_item(CMD_ENTRY, 1'b1, 16'd0, 16'd0, 32'h0000_8000));
    send_request(make_item(CMD_ENTRY, 1'b0, 16'd0, 16'd1, 32'hC000_0000));
    send_request(make_item(CMD_RHS, 1'b0, 16'd0, 16'd0, 32'h4000_0000));
    wait_all_results();
  endtask

  task automatic test_fill_under_hold();
    tx_idle = 1'b0;
    long_hold_cycles = 300;
    repeat (4) send_random_row();
    wait_all_results();
    tx_idle = 1'b1;
  endtask

  task automatic test_pause_until_drained();
    repeat (3) send_random_row();
    wait_all_results();
    repeat (3) send_random_row();
  endtask

  task automatic test_random_rows(input int target);
    while (requests_sent < target) begin
      if ($urandom_range(0, 9) == 0)
        send_request(make_item(1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
                               $urandom));
      else
        send_random_row();
    end
  endtask

  initial begin : receiver
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_cycles > 0) begin
        n = long_hold_cycles;
        long_hold_cycles = 0;
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end else if (rx_idle && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 9);
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    srids_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", out_data.scaled_value, 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.scaled_value !== want.scaled_value)
          report_mismatch("scaled_value", out_data.scaled_value, want.scaled_value);
        if (out_data.saturated !== want.saturated)
          report_mismatch("saturated", 32'(out_data.saturated), 32'(want.saturated));
        if (out_data.no_diagonal !== want.no_diagonal)
          report_mismatch("no_diagonal", 32'(out_data.no_diagonal), 32'(want.no_diagonal));
      end
    end
  end

  // Ends the run when no request moves on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("timeout: no request accepted for %0d cycles", STUCK_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_corners();
    test_fill_under_hold();
    test_pause_until_drained();
    test_random_rows(1200);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    test_random_rows(1500);
    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
